@@ hdl/arrc_pkg.sv @@
// Shared constants, codes and types of the adaptive resample ratio controller.
package arrc_pkg;

  // Field widths
  localparam int LVL_W   = 10;   // buffer levels, counts, thresholds
  localparam int GAIN_W  = 16;   // signed Q4.12 gains
  localparam int STEP_W  = 24;   // unsigned Q8.16 phase step
  localparam int LEN_CFG_W = 6;  // initial rate length register
  localparam int CFG_W   = 24;   // widest register
  localparam int CFG_IDX_W = 3;
  localparam int STATUS_W = 2;

  // Internal arithmetic widths
  localparam int HIST_W  = 16;             // one history entry
  localparam int SUM_W   = 24;             // window sums
  localparam int FRAC_W  = 16;             // Q.16 averages
  localparam int AVG_W   = 28;             // signed Q11.16 averages
  localparam int DIFF_W  = AVG_W + 1;      // change of the fill average
  localparam int GAIN_FRAC = 12;           // fraction bits of the gains
  localparam int PROD_W  = GAIN_W + DIFF_W;
  localparam int ACC_W   = 48;             // Q.28 step sum
  localparam int NUM_W   = SUM_W + FRAC_W; // divider dividend
  localparam int DIV_BITS  = 4;            // quotient bits per divider cycle
  localparam int DIV_STEPS = NUM_W / DIV_BITS;

  // Fixed design constants
  localparam int BATCH_SAMPLES   = 96;
  localparam int BUF_DEPTH       = 1024;
  localparam int RATE_WINDOW_DEF = 32;
  localparam int FILL_WINDOW_DEF = 32;

  localparam logic signed [ACC_W-1:0] BATCH_Q28 =
    ACC_W'(BATCH_SAMPLES) << (FRAC_W + GAIN_FRAC);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(BATCH_SAMPLES << FRAC_W);

  // Register reset values
  localparam logic [LVL_W-1:0]     IDEAL_RESET    = LVL_W'(512);
  localparam logic [LVL_W-1:0]     CRIT_RESET     = LVL_W'(128);
  localparam logic [GAIN_W-1:0]    GAIN_P_RESET   = GAIN_W'(256);
  localparam logic [GAIN_W-1:0]    GAIN_D_RESET   = GAIN_W'(0);
  localparam logic [STEP_W-1:0]    STEP_MIN_RESET = STEP_W'(6225920);
  localparam logic [STEP_W-1:0]    STEP_MAX_RESET = STEP_W'(6357000);
  localparam logic [LEN_CFG_W-1:0] INIT_LEN_RESET = LEN_CFG_W'(4);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IDEAL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRIT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_MAX = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_LEN = 3'd6;

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_BATCH = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_WRITE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_STEP  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BUSY  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_CRIT  = 2'd3;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ hdl/arrc_div.sv @@
// Shared signed divider: (dividend * 2^16) / divisor, truncated, saturated to Q11.16.
module arrc_div #(
  parameter int DIV_W = 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [arrc_pkg::SUM_W-1:0]  dividend_i,
  input  logic [DIV_W-1:0]                   divisor_i,
  output arrc_pkg::div_stat_t                stat_o,
  output logic signed [arrc_pkg::AVG_W-1:0]  quot_o
);
  import arrc_pkg::*;

  localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);
  localparam logic [NUM_W-1:0] POS_LIM  = NUM_W'((64'd1 << (AVG_W - 1)) - 64'd1);
  localparam logic [NUM_W-1:0] NEG_LIM  = NUM_W'(64'd1 << (AVG_W - 1));

  logic [NUM_W-1:0] num_q, num_d;
  logic [DIV_W:0]   rem_q, rem_d;
  logic [DIV_W-1:0] div_q;
  logic             neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q, done_q;
  logic [SUM_W-1:0] mag;

  assign mag = dividend_i[SUM_W-1] ? $unsigned(-dividend_i) : $unsigned(dividend_i);

  // Restoring division, several quotient bits per cycle
  always_comb begin
    rem_d = rem_q;
    num_d = num_q;
    for (int k = 0; k < DIV_BITS; k++) begin
      rem_d = {rem_d[DIV_W-1:0], num_d[NUM_W-1]};
      num_d = {num_d[NUM_W-2:0], 1'b0};
      if (rem_d >= {1'b0, div_q}) begin
        rem_d    = rem_d - {1'b0, div_q};
        num_d[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {mag, {FRAC_W{1'b0}}};
      rem_q <= '0;
      div_q <= divisor_i;
      neg_q <= dividend_i[SUM_W-1];
    end else if (run_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        run_q <= 1'b1;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Apply sign and saturate the magnitude
  always_comb begin
    if (!neg_q) begin
      quot_o = (num_q > POS_LIM) ? {1'b0, {(AVG_W-1){1'b1}}} : $signed(num_q[AVG_W-1:0]);
    end else begin
      quot_o = (num_q > NEG_LIM) ? {1'b1, {(AVG_W-1){1'b0}}} : -$signed(num_q[AVG_W-1:0]);
    end
  end

  assign stat_o.busy = run_q;
  assign stat_o.done = done_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !run_q)
    else $error("divider started while running");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (divisor_i != '0))
    else $error("divider started with zero divisor");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q && (cnt_q == CNT_LAST) && !start_i) |=> (done_q && !run_q))
    else $error("divider did not finish after last step");

endmodule

@@ hdl/adaptive_resample_ratio_control_core.sv @@
// Top level of the adaptive resample ratio controller: sequencer, windows, shared units.
//
//  channel   | direction | tdata (low bit up)                       | tuser
//  ----------+-----------+------------------------------------------+----------------
//  s_axis    | in        | written_count[9:0], buffer_level[19:10]  | operation
//  m_axis    | out       | phase_step, rate_error_avg, fill_avg     | status
//  cfg       | in        | cfg_index_i selects, cfg_data_i holds value (write only)
//
//  A write notice, a busy answer or a critical answer goes from idle straight
//  to the output step, which loads it into the output register. A batch step
//  runs two passes of the shared divider (4 quotient bits a cycle, rate average
//  then fill average), then multiply, accumulate and clamp through one shared
//  multiplier. The input is not ready until the result is loaded.
//  Reset clears all control state and loads the register defaults; the history
//  memories need no clearing pass, their per-entry valid bits reset at once.
//  A full output register stalls the sequencer in its output step only.
module adaptive_resample_ratio_control_core #(
  parameter int RATE_WINDOW = arrc_pkg::RATE_WINDOW_DEF,
  parameter int FILL_WINDOW = arrc_pkg::FILL_WINDOW_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [23:0]                      s_axis_tdata,   // written_count, buffer_level
  input  logic                             s_axis_tuser,   // operation
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [79:0]                      m_axis_tdata,   // phase_step, rate avg, fill avg
  output logic [arrc_pkg::STATUS_W-1:0]    m_axis_tuser,   // status
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [arrc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [arrc_pkg::CFG_W-1:0]       cfg_data_i
);
  import arrc_pkg::*;

  localparam int RP_W  = (RATE_WINDOW > 1) ? $clog2(RATE_WINDOW) : 1;
  localparam int FP_W  = (FILL_WINDOW > 1) ? $clog2(FILL_WINDOW) : 1;
  localparam int LEN_W = ($clog2(RATE_WINDOW + 1) > LEN_CFG_W) ?
                         $clog2(RATE_WINDOW + 1) : LEN_CFG_W;
  localparam int DIV_W = ($clog2(FILL_WINDOW + 1) > LEN_W) ?
                         $clog2(FILL_WINDOW + 1) : LEN_W;

  // Sequencer states
  localparam int S_W = 4;
  localparam logic [S_W-1:0] S_IDLE  = 4'd0;
  localparam logic [S_W-1:0] S_UPD   = 4'd1;
  localparam logic [S_W-1:0] S_RDIV  = 4'd2;
  localparam logic [S_W-1:0] S_RWAIT = 4'd3;
  localparam logic [S_W-1:0] S_FDIV  = 4'd4;
  localparam logic [S_W-1:0] S_FWAIT = 4'd5;
  localparam logic [S_W-1:0] S_MULP  = 4'd6;
  localparam logic [S_W-1:0] S_MULD  = 4'd7;
  localparam logic [S_W-1:0] S_ACC   = 4'd8;
  localparam logic [S_W-1:0] S_CLAMP = 4'd9;
  localparam logic [S_W-1:0] S_OUT   = 4'd10;

  logic [S_W-1:0] state_q, state_d;

  // Configuration registers
  logic [LVL_W-1:0]         ideal_q, crit_q;
  logic signed [GAIN_W-1:0] gain_p_q, gain_d_q;
  logic [STEP_W-1:0]        step_min_q, step_max_q;
  logic [LEN_CFG_W-1:0]     init_len_q;

  // Controller state
  logic                     ready_q;
  logic [HIST_W-1:0]        written_q;
  logic [RP_W-1:0]          rate_pos_q;
  logic [FP_W-1:0]          fill_pos_q;
  logic [LEN_W-1:0]         rate_len_q;
  logic signed [SUM_W-1:0]  rate_sum_q, fill_sum_q;
  logic signed [AVG_W-1:0]  last_favg_q;
  logic [STEP_W-1:0]        step_q;
  logic [RATE_WINDOW-1:0]   rate_vld_q;
  logic [FILL_WINDOW-1:0]   fill_vld_q;
  logic [STATUS_W-1:0]      res_status_q;

  // History memories
  logic signed [HIST_W-1:0] rate_mem [RATE_WINDOW];
  logic signed [HIST_W-1:0] fill_mem [FILL_WINDOW];
  logic signed [HIST_W-1:0] rate_rd_q, fill_rd_q;
  logic                     rate_vrd_q, fill_vrd_q;

  // Working registers
  logic signed [HIST_W-1:0] rerr_q, ferr_q;
  logic signed [AVG_W-1:0]  ravg_q, favg_q;
  logic signed [DIFF_W-1:0] dfill_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  // Output register
  logic                     out_valid_q;
  logic [STATUS_W-1:0]      out_status_q;
  logic [STEP_W-1:0]        out_step_q;
  logic signed [AVG_W-1:0]  out_ravg_q, out_favg_q;

  // Input fields
  logic             op;
  logic [LVL_W-1:0] count, level;
  logic             in_acc, out_load, arm, batch_go;

  assign op    = s_axis_tuser;
  assign count = s_axis_tdata[9:0];
  assign level = s_axis_tdata[19:10];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

  // Arm on a nonzero write while the buffer sits above ideal
  assign arm = in_acc && (op == OP_WRITE) && (count != '0) &&
               (32'(count) < BUF_DEPTH) && !ready_q && (level > ideal_q);
  assign batch_go = in_acc && (op == OP_BATCH) && ready_q && (level >= crit_q);

  // Window updates for the new entries
  logic signed [HIST_W-1:0] rate_old, fill_old;
  logic                     rate_full;
  logic signed [SUM_W-1:0]  rate_sum_d, fill_sum_d;
  logic [LEN_W-1:0]         rate_len_d;

  assign rate_old  = rate_vrd_q ? rate_rd_q : '0;
  assign fill_old  = fill_vrd_q ? fill_rd_q : '0;
  assign rate_full = (rate_len_q >= LEN_W'(RATE_WINDOW));

  always_comb begin
    rate_sum_d = rate_sum_q + {{(SUM_W-HIST_W){rerr_q[HIST_W-1]}}, rerr_q};
    rate_len_d = rate_len_q + 1'b1;
    if (rate_full) begin
      rate_sum_d = rate_sum_d - {{(SUM_W-HIST_W){rate_old[HIST_W-1]}}, rate_old};
      rate_len_d = LEN_W'(RATE_WINDOW);
    end
    fill_sum_d = fill_sum_q + {{(SUM_W-HIST_W){ferr_q[HIST_W-1]}}, ferr_q}
                            - {{(SUM_W-HIST_W){fill_old[HIST_W-1]}}, fill_old};
  end

  // Shared divider
  div_stat_t               div_stat;
  logic                    div_start;
  logic signed [SUM_W-1:0] div_num;
  logic [DIV_W-1:0]        div_den;
  logic signed [AVG_W-1:0] div_quot;

  assign div_start = (state_q == S_RDIV) || (state_q == S_FDIV);
  assign div_num   = (state_q == S_RDIV) ? rate_sum_q : fill_sum_q;
  assign div_den   = (state_q == S_RDIV) ? DIV_W'(rate_len_q) : DIV_W'(FILL_WINDOW);

  arrc_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  // Shared multiplier: gain_p * fill avg, then gain_d * fill change
  logic signed [GAIN_W-1:0] mul_a;
  logic signed [DIFF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_d;

  assign mul_a  = (state_q == S_MULP) ? gain_p_q : gain_d_q;
  assign mul_b  = (state_q == S_MULP) ? {favg_q[AVG_W-1], favg_q} : dfill_q;
  assign prod_d = mul_a * mul_b;

  // Floor to Q8.16, then clamp: lower limit first
  logic signed [ACC_W-1:0] total;
  logic [STEP_W-1:0]       step_d;

  assign total = acc_q >>> GAIN_FRAC;

  always_comb begin
    if (total < $signed({{(ACC_W-STEP_W){1'b0}}, step_min_q})) begin
      step_d = step_min_q;
    end else if (total > $signed({{(ACC_W-STEP_W){1'b0}}, step_max_q})) begin
      step_d = step_max_q;
    end else begin
      step_d = total[STEP_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = batch_go ? S_UPD : S_OUT;
      S_UPD:   state_d = S_RDIV;
      S_RDIV:  state_d = S_RWAIT;
      S_RWAIT: if (div_stat.done) state_d = S_FDIV;
      S_FDIV:  state_d = S_FWAIT;
      S_FWAIT: if (div_stat.done) state_d = S_MULP;
      S_MULP:  state_d = S_MULD;
      S_MULD:  state_d = S_ACC;
      S_ACC:   state_d = S_CLAMP;
      S_CLAMP: state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ideal_q      <= IDEAL_RESET;
      crit_q       <= CRIT_RESET;
      gain_p_q     <= GAIN_P_RESET;
      gain_d_q     <= GAIN_D_RESET;
      step_min_q   <= STEP_MIN_RESET;
      step_max_q   <= STEP_MAX_RESET;
      init_len_q   <= INIT_LEN_RESET;
      ready_q      <= 1'b0;
      written_q    <= '0;
      rate_pos_q   <= '0;
      fill_pos_q   <= '0;
      rate_len_q   <= LEN_W'(INIT_LEN_RESET);
      rate_sum_q   <= '0;
      fill_sum_q   <= '0;
      last_favg_q  <= '0;
      step_q       <= STEP_RESET;
      rate_vld_q   <= '0;
      fill_vld_q   <= '0;
      res_status_q <= STATUS_WRITE;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_IDEAL:    ideal_q    <= cfg_data_i[LVL_W-1:0];
          REG_CRIT:     crit_q     <= cfg_data_i[LVL_W-1:0];
          REG_GAIN_P:   gain_p_q   <= cfg_data_i[GAIN_W-1:0];
          REG_GAIN_D:   gain_d_q   <= cfg_data_i[GAIN_W-1:0];
          REG_STEP_MIN: step_min_q <= cfg_data_i[STEP_W-1:0];
          REG_STEP_MAX: step_max_q <= cfg_data_i[STEP_W-1:0];
          REG_INIT_LEN: init_len_q <= cfg_data_i[LEN_CFG_W-1:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        if (op == OP_WRITE) begin
          written_q    <= written_q + HIST_W'(count);
          res_status_q <= STATUS_WRITE;
          if (arm) begin
            // Restart both error windows
            ready_q     <= 1'b1;
            rate_vld_q  <= '0;
            fill_vld_q  <= '0;
            rate_pos_q  <= '0;
            fill_pos_q  <= '0;
            rate_len_q  <= LEN_W'(init_len_q);
            rate_sum_q  <= '0;
            fill_sum_q  <= '0;
            last_favg_q <= '0;
          end
        end else begin
          written_q <= '0;
          if (!ready_q) begin
            res_status_q <= STATUS_BUSY;
          end else if (level < crit_q) begin
            ready_q      <= 1'b0;
            res_status_q <= STATUS_CRIT;
          end else begin
            res_status_q <= STATUS_STEP;
          end
        end
      end

      if (state_q == S_UPD) begin
        rate_sum_q <= rate_sum_d;
        fill_sum_q <= fill_sum_d;
        rate_len_q <= rate_len_d;
        rate_vld_q[rate_pos_q] <= 1'b1;
        fill_vld_q[fill_pos_q] <= 1'b1;
        rate_pos_q <= (rate_pos_q == RP_W'(RATE_WINDOW - 1)) ? '0 : rate_pos_q + 1'b1;
        fill_pos_q <= (fill_pos_q == FP_W'(FILL_WINDOW - 1)) ? '0 : fill_pos_q + 1'b1;
      end

      if ((state_q == S_FWAIT) && div_stat.done) begin
        last_favg_q <= div_quot;
      end

      if (state_q == S_CLAMP) begin
        step_q <= step_d;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Rate history memory
  always_ff @(posedge clk_i) begin
    if (batch_go) begin
      rate_rd_q  <= rate_mem[rate_pos_q];
      rate_vrd_q <= rate_vld_q[rate_pos_q];
    end
    if (state_q == S_UPD) begin
      rate_mem[rate_pos_q] <= rerr_q;
    end
  end

  // Fill history memory
  always_ff @(posedge clk_i) begin
    if (batch_go) begin
      fill_rd_q  <= fill_mem[fill_pos_q];
      fill_vrd_q <= fill_vld_q[fill_pos_q];
    end
    if (state_q == S_UPD) begin
      fill_mem[fill_pos_q] <= ferr_q;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (batch_go) begin
      rerr_q <= written_q - HIST_W'(BATCH_SAMPLES);
      ferr_q <= $signed(HIST_W'(level)) - $signed(HIST_W'(ideal_q));
    end
    if ((state_q == S_RWAIT) && div_stat.done) begin
      ravg_q <= div_quot;
    end
    if ((state_q == S_FWAIT) && div_stat.done) begin
      favg_q  <= div_quot;
      dfill_q <= {div_quot[AVG_W-1], div_quot} - {last_favg_q[AVG_W-1], last_favg_q};
    end
    if ((state_q == S_MULP) || (state_q == S_MULD)) begin
      prod_q <= prod_d;
    end
    case (state_q)
      S_MULP:  acc_q <= BATCH_Q28 +
                        {{(ACC_W-AVG_W-GAIN_FRAC){ravg_q[AVG_W-1]}}, ravg_q,
                         {GAIN_FRAC{1'b0}}};
      S_MULD,
      S_ACC:   acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
      default: ;
    endcase
    if (out_load) begin
      out_status_q <= res_status_q;
      out_step_q   <= step_q;
      out_ravg_q   <= (res_status_q == STATUS_STEP) ? ravg_q : '0;
      out_favg_q   <= (res_status_q == STATUS_STEP) ? favg_q : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {out_favg_q, out_ravg_q, out_step_q};

  a_work_needs_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != S_IDLE) && (state_q != S_OUT)) |-> ready_q)
    else $error("step computed while controller not ready");

  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !div_stat.busy)
    else $error("divider still running in idle");

  a_rate_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDIV) |-> ((rate_len_q != '0) && (rate_len_q <= LEN_W'(RATE_WINDOW))))
    else $error("rate divisor out of range");

endmodule

@@ sim/tb_top.sv @@
// Self-checking stream testbench of the adaptive resample ratio controller core.
`timescale 1ns / 100ps

module tb_top;
  import arrc_pkg::*;

  localparam int     CYCLE_LIMIT  = 600000;
  localparam int     HOLDOFF_AT   = 300;    // results seen before the long output hold-off
  localparam int     HOLDOFF_LEN  = 400;
  localparam int     SETTLE_CYC   = 8;
  localparam int     TAIL_CYC     = 64;
  localparam int     MAX_REPORTED = 200;
  localparam longint AVG_MAX      = 64'sd134217727;
  localparam longint AVG_MIN      = -64'sd134217728;

  // one input transaction: write notice or batch request
  typedef struct packed {
    logic             op;
    logic [LVL_W-1:0] count;
    logic [LVL_W-1:0] level;
  } notice_t;

  // one result transaction
  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [STEP_W-1:0]       step;
    logic signed [AVG_W-1:0] ravg;
    logic signed [AVG_W-1:0] favg;
  } report_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PATTERN} rx_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata = '0;   // written_count[9:0], buffer_level[19:10]
  logic                 s_axis_tuser = 1'b0; // operation
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [79:0]          m_axis_tdata;        // phase_step[23:0], rate avg[51:24], fill avg[79:52]
  logic [STATUS_W-1:0]  m_axis_tuser;        // status
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  adaptive_resample_ratio_control_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Controller mirror: register copy and control state, updated at each edge
  // on which a register write or an input transaction happens.
  // ---------------------------------------------------------------------------
  logic [LVL_W-1:0]     cfg_ideal    = IDEAL_RESET;
  logic [LVL_W-1:0]     cfg_crit     = CRIT_RESET;
  shortint              cfg_gain_p   = GAIN_P_RESET;
  shortint              cfg_gain_d   = GAIN_D_RESET;
  logic [STEP_W-1:0]    cfg_step_min = STEP_MIN_RESET;
  logic [STEP_W-1:0]    cfg_step_max = STEP_MAX_RESET;
  logic [LEN_CFG_W-1:0] cfg_init_len = INIT_LEN_RESET;

  logic              armed        = 1'b0;
  logic [15:0]       written_acc  = '0;
  shortint           rate_hist [RATE_WINDOW_DEF];
  int                fill_hist [FILL_WINDOW_DEF];
  int                rate_pos, rate_len, rate_sum;
  int                fill_pos, fill_sum;
  longint            last_favg;
  logic [STEP_W-1:0] held_step    = STEP_RESET;

  notice_t notices_q[$];        // items waiting for the driver
  report_t pending_reports[$];  // results owed by the block, oldest first

  int  err_cnt       = 0;
  int  accepted_cnt  = 0;
  int  reports_seen  = 0;
  int  cycle_cnt     = 0;
  int  settings_cnt  = 1;
  int  status_seen [4];
  logic in_fire      = 1'b0;

  // Drop both error windows and restart the rate divisor.
  function automatic void clear_windows();
    for (int i = 0; i < RATE_WINDOW_DEF; i++) rate_hist[i] = 0;
    for (int i = 0; i < FILL_WINDOW_DEF; i++) fill_hist[i] = 0;
    rate_pos  = 0;
    fill_pos  = 0;
    rate_sum  = 0;
    fill_sum  = 0;
    rate_len  = cfg_init_len;
    last_favg = 0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      REG_IDEAL:    cfg_ideal    = val[LVL_W-1:0];
      REG_CRIT:     cfg_crit     = val[LVL_W-1:0];
      REG_GAIN_P:   cfg_gain_p   = val[GAIN_W-1:0];
      REG_GAIN_D:   cfg_gain_d   = val[GAIN_W-1:0];
      REG_STEP_MIN: cfg_step_min = val[STEP_W-1:0];
      REG_STEP_MAX: cfg_step_max = val[STEP_W-1:0];
      REG_INIT_LEN: cfg_init_len = val[LEN_CFG_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the mirror by one transaction and return the result it owes.
  function automatic report_t compute_ratio_result(notice_t n);
    report_t          r;
    logic signed [15:0] rerr;
    int               ferr;
    longint           ravg, favg, diff, total;
    ravg = 0;
    favg = 0;
    if (n.op == OP_WRITE) begin
      // arm only on a nonzero count with the buffer above its ideal fill
      if (n.count != 0 && !armed && n.level > cfg_ideal) begin
        clear_windows();
        armed = 1'b1;
      end
      written_acc = written_acc + 16'(n.count);
      r.status = STATUS_WRITE;
    end else if (!armed) begin
      written_acc = '0;
      r.status = STATUS_BUSY;
    end else if (n.level < cfg_crit) begin
      // drained below the stop threshold: disarm and ask input to stop
      armed = 1'b0;
      written_acc = '0;
      r.status = STATUS_CRIT;
    end else begin
      rerr = written_acc - 16'(BATCH_SAMPLES);
      ferr = int'(n.level) - int'(cfg_ideal);
      written_acc = '0;
      // rate divisor grows until the window is full, then the oldest entry drops out
      if (rate_len >= RATE_WINDOW_DEF) begin
        rate_len = RATE_WINDOW_DEF;
        rate_sum -= rate_hist[rate_pos];
      end else begin
        rate_len++;
      end
      rate_sum += rerr;
      rate_hist[rate_pos] = rerr;
      fill_sum = fill_sum - fill_hist[fill_pos] + ferr;
      fill_hist[fill_pos] = ferr;
      rate_pos = (rate_pos + 1) % RATE_WINDOW_DEF;
      fill_pos = (fill_pos + 1) % FILL_WINDOW_DEF;

      ravg = (longint'(rate_sum) * 64'sd65536) / longint'(rate_len);
      if (ravg > AVG_MAX) ravg = AVG_MAX;
      if (ravg < AVG_MIN) ravg = AVG_MIN;
      favg = (longint'(fill_sum) * 64'sd65536) / longint'(FILL_WINDOW_DEF);
      if (favg > AVG_MAX) favg = AVG_MAX;
      if (favg < AVG_MIN) favg = AVG_MIN;
      diff = favg - last_favg;
      last_favg = favg;

      // exact Q.28 sum, floored to Q8.16, then the ordered clamp
      total = (longint'(BATCH_SAMPLES) <<< 28) + ravg * 4096
            + longint'(cfg_gain_p) * favg + longint'(cfg_gain_d) * diff;
      total = total >>> 12;
      if (total < longint'(cfg_step_min))      total = longint'(cfg_step_min);
      else if (total > longint'(cfg_step_max)) total = longint'(cfg_step_max);
      held_step = total[STEP_W-1:0];
      r.status = STATUS_STEP;
    end
    r.step = held_step;
    r.ravg = ravg[AVG_W-1:0];
    r.favg = favg[AVG_W-1:0];
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want !== got) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTED)
        $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: mirror register writes, predict on every input transaction and
  // compare every output transaction with the oldest pending result.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    notice_t n;
    report_t want, got;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni) begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (cfg_we_i) apply_reg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) begin
        n.op    = s_axis_tuser;
        n.count = s_axis_tdata[LVL_W-1:0];
        n.level = s_axis_tdata[2*LVL_W-1:LVL_W];
        pending_reports.push_back(compute_ratio_result(n));
        accepted_cnt++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tuser;
        got.step   = m_axis_tdata[23:0];
        got.ravg   = m_axis_tdata[51:24];
        got.favg   = m_axis_tdata[79:52];
        reports_seen++;
        if (pending_reports.size() == 0) begin
          err_cnt++;
          $error("result with none pending: status %0d", got.status);
        end else begin
          want = pending_reports.pop_front();
          status_seen[want.status]++;
          check_field("status", want.status, got.status);
          check_field("phase_step", want.step, got.step);
          check_field("rate_error_avg", longint'(want.ravg), longint'(got.ravg));
          check_field("fill_error_avg", longint'(want.favg), longint'(got.favg));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: offer queued items in bursts separated by random gaps; hold an
  // item until its transaction completes.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk_i) begin : driver
    notice_t cur;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !in_fire) begin
      // hold: transaction still pending
    end else if (gap_left > 0) begin
      s_axis_tvalid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (notices_q.size() > 0) begin
      cur = notices_q.pop_front();
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {4'b0, cur.level, cur.count};
      s_axis_tuser  <= cur.op;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 60);
        // about a third of the bursts run back to back
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 :
                    ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50) :
                                                   $urandom_range(1, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: switch between stall patterns; once, hold off for a long stretch
  // so the output register fills and the block stalls its input.
  // ---------------------------------------------------------------------------
  rx_mode_e   rx_mode      = RX_OPEN;
  int         mode_left    = 0;
  int         holdoff_left = 0;
  logic       holdoff_done = 1'b0;
  logic [2:0] pattern_cnt  = '0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (holdoff_left > 0) begin
      m_axis_tready <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else if (!holdoff_done && reports_seen >= HOLDOFF_AT) begin
      holdoff_done <= 1'b1;
      holdoff_left <= HOLDOFF_LEN;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
        mode_left <= $urandom_range(16, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:    m_axis_tready <= 1'b1;
        RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
        RX_MOSTLY:  m_axis_tready <= ($urandom_range(0, 9) != 0);
        default:    m_axis_tready <= (pattern_cnt < 3'd5);
      endcase
      pattern_cnt <= pattern_cnt + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic int clamp_level(int v);
    return (v < 0) ? 0 : (v > 1023) ? 1023 : v;
  endfunction

  task automatic queue_notice(logic op, int cnt, int lvl);
    notice_t n;
    n.op    = op;
    n.count = cnt[LVL_W-1:0];
    n.level = lvl[LVL_W-1:0];
    notices_q.push_back(n);
  endtask

  // Wait until the block is idle: nothing queued, nothing offered, nothing owed.
  task automatic drain();
    while (notices_q.size() != 0 || s_axis_tvalid || pending_reports.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
  endtask

  task automatic program_regs(int ideal, int crit, int gp, int gd, int smin, int smax,
                              int init_len);
    write_reg(REG_IDEAL,    CFG_W'(LVL_W'(ideal)));
    write_reg(REG_CRIT,     CFG_W'(LVL_W'(crit)));
    write_reg(REG_GAIN_P,   CFG_W'(GAIN_W'(gp)));
    write_reg(REG_GAIN_D,   CFG_W'(GAIN_W'(gd)));
    write_reg(REG_STEP_MIN, CFG_W'(smin));
    write_reg(REG_STEP_MAX, CFG_W'(smax));
    write_reg(REG_INIT_LEN, CFG_W'(LEN_CFG_W'(init_len)));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    settings_cnt++;
  endtask

  // Mostly steady audio flow around the ideal fill, with drains, long write
  // runs, zero-count notices and plain noise mixed in.
  task automatic gen_traffic(int n);
    int made, kind, lvl, reps, cnt;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(0, 99);
      lvl  = clamp_level(int'(cfg_ideal) + int'($urandom_range(0, 160)) - 80);
      if (kind < 70) begin
        reps = $urandom_range(1, 2);
        for (int i = 0; i < reps; i++) begin
          cnt = (BATCH_SAMPLES + int'($urandom_range(0, 16)) - 8) / reps;
          queue_notice(OP_WRITE, cnt, lvl);
        end
        queue_notice(OP_BATCH, 0, clamp_level(lvl + int'($urandom_range(0, 20)) - 10));
        made += reps + 1;
      end else if (kind < 82) begin
        queue_notice(1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                     $urandom_range(0, 1023));
        made++;
      end else if (kind < 90) begin
        // drain below the stop threshold, then refill to re-arm
        queue_notice(OP_BATCH, $urandom_range(0, 1023),
                     (cfg_crit == 0) ? 0 : $urandom_range(0, int'(cfg_crit) - 1));
        queue_notice(OP_WRITE, BATCH_SAMPLES,
                     clamp_level(int'(cfg_ideal) + int'($urandom_range(1, 60))));
        made += 2;
      end else if (kind < 95) begin
        // long write run; big counts push the running counter past its wrap
        reps = $urandom_range(2, 90);
        for (int i = 0; i < reps; i++)
          queue_notice(OP_WRITE, $urandom_range(0, 1023), $urandom_range(0, 1023));
        queue_notice(OP_BATCH, 0, lvl);
        made += reps + 1;
      end else begin
        queue_notice(OP_WRITE, 0, clamp_level(int'(cfg_ideal) + 1));
        made++;
      end
    end
  endtask

  initial begin
    clear_windows();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part under the reset register values (ideal 512, stop 128).
    queue_notice(OP_BATCH, 0, 600);        // not armed yet: busy
    queue_notice(OP_WRITE, 0, 1023);       // zero count never arms
    queue_notice(OP_WRITE, 1023, 512);     // level equal to ideal does not arm
    queue_notice(OP_BATCH, 1023, 1023);    // busy answer clears the counter
    queue_notice(OP_WRITE, 96, 513);       // arms
    queue_notice(OP_BATCH, 0, 513);
    queue_notice(OP_WRITE, 96, 1023);
    queue_notice(OP_BATCH, 0, 1023);
    queue_notice(OP_WRITE, 0, 0);
    queue_notice(OP_BATCH, 0, 128);        // at the stop threshold: still a step
    queue_notice(OP_BATCH, 0, 127);        // below it: critical, disarm
    queue_notice(OP_BATCH, 0, 600);        // busy again
    queue_notice(OP_WRITE, 1, 1023);       // smallest count arms
    queue_notice(OP_WRITE, 1023, 0);
    queue_notice(OP_WRITE, 1023, 0);
    queue_notice(OP_BATCH, 0, 700);        // large positive rate error
    queue_notice(OP_WRITE, 1023, 1023);    // already armed: windows kept
    queue_notice(OP_BATCH, 0, 1023);
    queue_notice(OP_BATCH, 0, 1023);       // no writes: rate error at its low end
    queue_notice(OP_BATCH, 0, 0);          // critical
    gen_traffic(150);
    drain();

    // Wide limits, moderate gains, divisor starting at one.
    program_regs(512, 128, 4096, 2048, 0, 24'hFFFFFF, 1);
    gen_traffic(160);
    drain();

    // Extreme gains of opposite sign, full window from the start, no stop level.
    program_regs(300, 0, 32767, -32768, 0, 24'hFFFFFF, 32);
    gen_traffic(160);
    drain();

    // Crossed limits, top ideal fill so nothing arms anew, length above window.
    program_regs(1023, 200, 256, 0, 24'h700000, 24'h500000, 63);
    gen_traffic(160);
    drain();

    // Bottom ideal fill, top stop level, inverted extreme gains, zero initial length.
    program_regs(0, 1023, -32768, 32767, 0, 6357000, 0);
    gen_traffic(160);
    drain();

    program_regs(700, 50, int'($urandom_range(0, 65535)) - 32768,
                 int'($urandom_range(0, 65535)) - 32768, 5000000, 7000000,
                 $urandom_range(1, 32));
    gen_traffic(160);
    drain();

    program_regs($urandom_range(0, 1023), $urandom_range(0, 400),
                 int'($urandom_range(0, 65535)) - 32768,
                 int'($urandom_range(0, 65535)) - 32768,
                 $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                 $urandom_range(0, 63));
    gen_traffic(160);
    drain();

    repeat (TAIL_CYC) @(posedge clk_i);
    $display("Ran %0d input transactions under %0d register settings in %0d cycles.",
             accepted_cnt, settings_cnt, cycle_cnt);
    $display("Results: %0d write, %0d step, %0d not ready, %0d critical; %0d mismatches.",
             status_seen[STATUS_WRITE], status_seen[STATUS_STEP],
             status_seen[STATUS_BUSY], status_seen[STATUS_CRIT], err_cnt);
    if (err_cnt == 0) begin
      $display("adaptive_resample_ratio_control_core regression: pass");
    end else begin
      $display("adaptive_resample_ratio_control_core regression: fail");
    end
    $finish;
  end

  // Watchdog on the cycle counter.
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d results pending.",
             cycle_cnt, pending_reports.size());
    $display("adaptive_resample_ratio_control_core regression: fail");
    $finish;
  end

endmodule
